/* rtl/iol_pkg.sv */
// Package for the indexed ordered list: sizes, request and status codes, cell control.
package iol_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;

  // fixed port widths
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // internal widths
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [TYPE_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_READ   = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // control broadcast to every cell in the chain
  typedef struct packed {
    logic             append;
    logic             remove;
    logic             read;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] count;
  } iol_ctrl_t;

endpackage

/* rtl/iol_cell.sv */
// One list slot: holds a value, loads on append, takes its neighbor's value on remove.
module iol_cell (
  input  logic                          clk_i,
  input  logic [iol_pkg::CMP_W-1:0]     index_i,
  input  iol_pkg::iol_ctrl_t            ctrl_i,
  input  logic [iol_pkg::DATA_WIDTH-1:0] append_value_i,
  input  logic [iol_pkg::DATA_WIDTH-1:0] next_value_i,
  output logic [iol_pkg::DATA_WIDTH-1:0] value_o,
  output logic [iol_pkg::DATA_WIDTH-1:0] hit_value_o
);
  import iol_pkg::*;

  logic [DATA_WIDTH-1:0] value_q, value_d;

  // slot update: append lands at the tail, remove shifts later slots forward
  always_comb begin
    value_d = value_q;
    if (ctrl_i.append && (index_i == ctrl_i.count)) begin
      value_d = append_value_i;
    end else if (ctrl_i.remove && (index_i >= ctrl_i.pos)) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

  // read tap, zero unless this slot is addressed
  assign hit_value_o = (ctrl_i.read && (index_i == ctrl_i.pos)) ? value_q : '0;

endmodule

/* rtl/indexed_ordered_list.sv */
// Top level of the indexed ordered list: request decode, cell chain and result register.
//
//  channel | valid      | ready      | payload
//  --------+------------+------------+----------------------------------------
//  request | in_valid_i | in_ready_o | req_type_i, item_value_i, position_i
//  result  | out_valid_o| out_ready_i| read_value_o, status_o, entry_count_o
//
// The cell chain shifts every later entry toward the front in the same edge that
// accepts the request, so one request per cycle is sustained while the result is
// drained. The result is loaded into an output register by the accepting edge.
// A request is taken while that register is empty or being drained this cycle.
// Reset empties the list; slot contents are not cleared.
module indexed_ordered_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [iol_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [iol_pkg::VALUE_W-1:0] item_value_i,
  input  logic [iol_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [iol_pkg::VALUE_W-1:0] read_value_o,
  output logic [iol_pkg::STAT_W-1:0]  status_o,
  output logic [iol_pkg::COUNT_W-1:0] entry_count_o
);
  import iol_pkg::*;

  logic                  accept;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      count_ext;
  logic                  in_range;
  logic                  not_full;
  iol_ctrl_t             ctrl;
  status_e               status;
  logic [CNT_W-1:0]      held_count_q, held_count_d;
  logic                  out_valid_q;
  logic [STAT_W-1:0]     status_q;
  logic [CNT_W-1:0]      count_q;
  logic [DATA_WIDTH-1:0] read_q;
  logic [DATA_WIDTH-1:0] append_value;
  logic [DATA_WIDTH-1:0] read_sel;

  logic [DATA_WIDTH-1:0] cell_value [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_hit   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_next  [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_ext      = CMP_W'(position_i);
  assign count_ext    = CMP_W'(held_count_q);
  assign in_range     = pos_ext < count_ext;
  assign not_full     = held_count_q < CNT_W'(CAPACITY);
  assign append_value = DATA_WIDTH'(item_value_i);

  // request decode
  always_comb begin
    ctrl         = '0;
    ctrl.pos     = pos_ext;
    ctrl.count   = count_ext;
    status       = ST_RANGE;
    held_count_d = held_count_q;
    case (req_type_i)
      REQ_APPEND: begin
        if (not_full) begin
          status       = ST_OK;
          ctrl.append  = accept;
          held_count_d = held_count_q + CNT_W'(1);
        end else begin
          status = ST_FULL;
        end
      end
      REQ_READ: begin
        if (in_range) begin
          status    = ST_OK;
          ctrl.read = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (in_range) begin
          status       = ST_OK;
          ctrl.remove  = accept;
          held_count_d = held_count_q - CNT_W'(1);
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // cell chain; the last slot takes don't-care data on a shift
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      assign cell_next[i] = '0;
    end else begin : g_link
      assign cell_next[i] = cell_value[i+1];
    end

    iol_cell u_cell (
      .clk_i          (clk_i),
      .index_i        (CMP_W'(i)),
      .ctrl_i         (ctrl),
      .append_value_i (append_value),
      .next_value_i   (cell_next[i]),
      .value_o        (cell_value[i]),
      .hit_value_o    (cell_hit[i])
    );
  end

  // at most one tap is nonzero
  always_comb begin
    read_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_sel = read_sel | cell_hit[i];
    end
  end

  // list count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= '0;
    end else if (accept) begin
      held_count_q <= held_count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
      count_q  <= held_count_d;
      read_q   <= read_sel;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = COUNT_W'(count_q);
  assign read_value_o  = VALUE_W'(read_q);

endmodule
